FILE: rtl/sws_pkg.sv
`default_nettype none

package sws_pkg;

	// Input item kinds
	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Result kinds
	localparam logic [1:0] RK_BYTE     = 2'd0;
	localparam logic [1:0] RK_WORD_END = 2'd1;
	localparam logic [1:0] RK_STATUS   = 2'd2;

	// Final status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNCLOSED = 2'd1;
	localparam logic [1:0] ST_NO_ESC   = 2'd2;

	// Characters with a meaning to the splitter
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// One result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] status;
	} result_t;

	// Work for the back end: one result, or two when two is set
	typedef struct packed {
		logic    two;
		result_t res0;
		result_t res1;
	} cmd_t;

	function automatic result_t mk_byte(input logic [7:0] b);
		result_t r;
		r.kind   = RK_BYTE;
		r.data   = b;
		r.status = ST_OK;
		return r;
	endfunction

	function automatic result_t mk_word_end();
		result_t r;
		r.kind   = RK_WORD_END;
		r.data   = 8'd0;
		r.status = ST_OK;
		return r;
	endfunction

	function automatic result_t mk_status(input logic [1:0] st);
		result_t r;
		r.kind   = RK_STATUS;
		r.data   = 8'd0;
		r.status = st;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/shell_word_splitter.sv
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+------------------------------------------
// input    | in        | in_valid/in_stall  | kind, data_byte
// output   | out       | out_valid/out_stall| result_kind, word_byte, status,
//          |           |                    | last_of_item
//
// One input transaction is taken per cycle while the command queue has room.
// Each result occupies the output register on its own, so an item with two
// results (kept backslash in double quotes, word end before final status)
// holds the back end until both have left; the QUEUE_DEPTH-entry queue absorbs them.
// Each item is registered in a queue slot and then in the output register.
// Reset (arst_n low) drops all queued work and returns to outside quotes,
// no open word. No clearing pass is needed.
// in_stall rises only when the queue is full; out_stall only holds the back end.

module shell_word_splitter #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire         kind,
	input  wire  [7:0]  data_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  word_byte,
	output logic [1:0]  status,
	output logic        last_of_item
);

	logic           accept;
	logic           push;
	logic           q_full;
	logic           q_valid;
	logic           pop;
	sws_pkg::cmd_t  wr_cmd;
	sws_pkg::cmd_t  rd_cmd;

	// Hold the input whenever the queue cannot take another command
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// Front: track quoting mode and turn each byte into zero, one or two results
	sws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.data_byte (data_byte),
		.push      (push),
		.cmd       (wr_cmd)
	);

	// Decouple classification from delivery
	sws_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (wr_cmd),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_cmd   (rd_cmd)
	);

	// Back: advance one result per free output slot
	sws_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd          (rd_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.word_byte    (word_byte),
		.status       (status),
		.last_of_item (last_of_item)
	);

`ifndef SYNTHESIS
	// A final status always closes its item
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == sws_pkg::RK_STATUS |-> last_of_item)
		else $error("final status not marked last of item");

	// Only word bytes carry data
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != sws_pkg::RK_BYTE |-> word_byte == 8'd0)
		else $error("non-byte result carries a data byte");

	// Only final statuses carry a status code
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != sws_pkg::RK_STATUS |-> status == sws_pkg::ST_OK)
		else $error("status code on a non-status result");

	// A word end is never the first of a two-result item's pair except before a status
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_item && result_kind == sws_pkg::RK_WORD_END
		|=> out_valid && result_kind == sws_pkg::RK_STATUS)
		else $error("word end not followed by final status");
`endif

endmodule

`default_nettype wire

FILE: rtl/sws_front.sv
`default_nettype none

module sws_front (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             accept,
	input  wire             kind,
	input  wire  [7:0]      data_byte,
	output logic            push,
	output sws_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		MODE_OUT,
		MODE_OUT_ESC,
		MODE_SQ,
		MODE_DQ,
		MODE_DQ_ESC
	} mode_t;

	mode_t mode_q;
	mode_t mode_nxt;
	logic  word_open_q;
	logic  word_open_nxt;
	logic  emit;
	logic  is_sep;

	assign is_sep = (data_byte == sws_pkg::CH_SPACE) || (data_byte == sws_pkg::CH_TAB) ||
		(data_byte == sws_pkg::CH_CR) || (data_byte == sws_pkg::CH_LF);

	always_comb begin
		mode_nxt      = mode_q;
		word_open_nxt = word_open_q;
		emit          = 1'b0;
		cmd.two       = 1'b0;
		cmd.res0      = sws_pkg::mk_byte(data_byte);
		cmd.res1      = sws_pkg::mk_byte(data_byte);
		if (kind == sws_pkg::KIND_END) begin
			emit          = 1'b1;
			mode_nxt      = MODE_OUT;
			word_open_nxt = 1'b0;
			case (mode_q)
				MODE_SQ, MODE_DQ: begin
					cmd.res0 = sws_pkg::mk_status(sws_pkg::ST_UNCLOSED);
				end
				MODE_OUT_ESC, MODE_DQ_ESC: begin
					cmd.res0 = sws_pkg::mk_status(sws_pkg::ST_NO_ESC);
				end
				default: begin
					if (word_open_q) begin
						cmd.two  = 1'b1;
						cmd.res0 = sws_pkg::mk_word_end();
						cmd.res1 = sws_pkg::mk_status(sws_pkg::ST_OK);
					end else begin
						cmd.res0 = sws_pkg::mk_status(sws_pkg::ST_OK);
					end
				end
			endcase
		end else begin
			case (mode_q)
				MODE_OUT_ESC: begin
					emit          = 1'b1;
					word_open_nxt = 1'b1;
					mode_nxt      = MODE_OUT;
				end
				MODE_SQ: begin
					if (data_byte == sws_pkg::CH_SQUOTE)
						mode_nxt = MODE_OUT;
					else
						emit = 1'b1;
				end
				MODE_DQ: begin
					if (data_byte == sws_pkg::CH_DQUOTE)
						mode_nxt = MODE_OUT;
					else if (data_byte == sws_pkg::CH_BSLASH)
						mode_nxt = MODE_DQ_ESC;
					else
						emit = 1'b1;
				end
				MODE_DQ_ESC: begin
					emit     = 1'b1;
					mode_nxt = MODE_DQ;
					// keep the backslash unless it escapes a quote or backslash
					if (data_byte != sws_pkg::CH_DQUOTE && data_byte != sws_pkg::CH_BSLASH) begin
						cmd.two  = 1'b1;
						cmd.res0 = sws_pkg::mk_byte(sws_pkg::CH_BSLASH);
					end
				end
				default: begin
					mode_nxt = MODE_OUT;
					if (is_sep) begin
						if (word_open_q) begin
							emit          = 1'b1;
							cmd.res0      = sws_pkg::mk_word_end();
							word_open_nxt = 1'b0;
						end
					end else if (data_byte == sws_pkg::CH_SQUOTE) begin
						mode_nxt      = MODE_SQ;
						word_open_nxt = 1'b1;
					end else if (data_byte == sws_pkg::CH_DQUOTE) begin
						mode_nxt      = MODE_DQ;
						word_open_nxt = 1'b1;
					end else if (data_byte == sws_pkg::CH_BSLASH) begin
						mode_nxt = MODE_OUT_ESC;
					end else begin
						emit          = 1'b1;
						word_open_nxt = 1'b1;
					end
				end
			endcase
		end
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_OUT;
			word_open_q <= 1'b0;
		end else if (accept) begin
			mode_q      <= mode_nxt;
			word_open_q <= word_open_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sws_queue.sv
`default_nettype none

module sws_queue #(
	parameter int DEPTH = 4
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  sws_pkg::cmd_t   wr_cmd,
	output logic            full,
	input  wire             pop,
	output logic            rd_valid,
	output sws_pkg::cmd_t   rd_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sws_pkg::cmd_t    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sws_back.sv
`default_nettype none

module sws_back (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             cmd_valid,
	input  sws_pkg::cmd_t   cmd,
	output logic            pop,
	output logic            out_valid,
	input  wire             out_stall,
	output logic [1:0]      result_kind,
	output logic [7:0]      word_byte,
	output logic [1:0]      status,
	output logic            last_of_item
);

	logic              valid_q;
	sws_pkg::result_t  res_q;
	logic              last_q;
	logic              sec_valid_q;
	sws_pkg::result_t  sec_q;
	logic              load;

	// output register is free when empty or being taken this cycle
	assign load = !valid_q || !out_stall;
	assign pop  = load && !sec_valid_q && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (load) begin
			if (sec_valid_q) begin
				valid_q     <= 1'b1;
				sec_valid_q <= 1'b0;
			end else begin
				valid_q     <= cmd_valid;
				sec_valid_q <= cmd_valid && cmd.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sec_valid_q) begin
				res_q  <= sec_q;
				last_q <= 1'b1;
			end else begin
				res_q  <= cmd.res0;
				last_q <= !cmd.two;
				sec_q  <= cmd.res1;
			end
		end
	end

	assign out_valid    = valid_q;
	assign result_kind  = res_q.kind;
	assign word_byte    = res_q.data;
	assign status       = res_q.status;
	assign last_of_item = last_q;

endmodule

`default_nettype wire
